[hdl/ecpu_pkg.sv]
// operation codes, status flag positions and shared helpers for the execute unit
package ecpu_pkg;

  localparam int unsigned CmdW   = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 64;

  // reset values of the architectural state
  localparam logic [ByteW-1:0] SP_RESET = 8'hFD;
  localparam logic [ByteW-1:0] P_RESET  = 8'h24;

  // status register bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_ONE = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  // operation codes
  localparam logic [CmdW-1:0] CMD_LDA = 6'd0;
  localparam logic [CmdW-1:0] CMD_LDX = 6'd1;
  localparam logic [CmdW-1:0] CMD_LDY = 6'd2;
  localparam logic [CmdW-1:0] CMD_STA = 6'd3;
  localparam logic [CmdW-1:0] CMD_STX = 6'd4;
  localparam logic [CmdW-1:0] CMD_STY = 6'd5;
  localparam logic [CmdW-1:0] CMD_ADC = 6'd6;
  localparam logic [CmdW-1:0] CMD_SBC = 6'd7;
  localparam logic [CmdW-1:0] CMD_AND = 6'd8;
  localparam logic [CmdW-1:0] CMD_ORA = 6'd9;
  localparam logic [CmdW-1:0] CMD_EOR = 6'd10;
  localparam logic [CmdW-1:0] CMD_ASL = 6'd11;
  localparam logic [CmdW-1:0] CMD_LSR = 6'd12;
  localparam logic [CmdW-1:0] CMD_ROL = 6'd13;
  localparam logic [CmdW-1:0] CMD_ROR = 6'd14;
  localparam logic [CmdW-1:0] CMD_INC = 6'd15;
  localparam logic [CmdW-1:0] CMD_DEC = 6'd16;
  localparam logic [CmdW-1:0] CMD_INX = 6'd17;
  localparam logic [CmdW-1:0] CMD_INY = 6'd18;
  localparam logic [CmdW-1:0] CMD_DEX = 6'd19;
  localparam logic [CmdW-1:0] CMD_DEY = 6'd20;
  localparam logic [CmdW-1:0] CMD_CMP = 6'd21;
  localparam logic [CmdW-1:0] CMD_CPX = 6'd22;
  localparam logic [CmdW-1:0] CMD_CPY = 6'd23;
  localparam logic [CmdW-1:0] CMD_BIT = 6'd24;
  localparam logic [CmdW-1:0] CMD_BCC = 6'd25;
  localparam logic [CmdW-1:0] CMD_BCS = 6'd26;
  localparam logic [CmdW-1:0] CMD_BEQ = 6'd27;
  localparam logic [CmdW-1:0] CMD_BNE = 6'd28;
  localparam logic [CmdW-1:0] CMD_BMI = 6'd29;
  localparam logic [CmdW-1:0] CMD_BPL = 6'd30;
  localparam logic [CmdW-1:0] CMD_BVC = 6'd31;
  localparam logic [CmdW-1:0] CMD_BVS = 6'd32;
  localparam logic [CmdW-1:0] CMD_JMP = 6'd33;
  localparam logic [CmdW-1:0] CMD_CLC = 6'd34;
  localparam logic [CmdW-1:0] CMD_CLD = 6'd35;
  localparam logic [CmdW-1:0] CMD_CLI = 6'd36;
  localparam logic [CmdW-1:0] CMD_CLV = 6'd37;
  localparam logic [CmdW-1:0] CMD_SEC = 6'd38;
  localparam logic [CmdW-1:0] CMD_SED = 6'd39;
  localparam logic [CmdW-1:0] CMD_SEI = 6'd40;
  localparam logic [CmdW-1:0] CMD_TAX = 6'd41;
  localparam logic [CmdW-1:0] CMD_TAY = 6'd42;
  localparam logic [CmdW-1:0] CMD_TSX = 6'd43;
  localparam logic [CmdW-1:0] CMD_TXA = 6'd44;
  localparam logic [CmdW-1:0] CMD_TXS = 6'd45;
  localparam logic [CmdW-1:0] CMD_TYA = 6'd46;
  localparam logic [CmdW-1:0] CMD_NOP = 6'd47;

  typedef struct packed {
    logic [AddrW-1:0] next_pc;
    logic [AddrW-1:0] jump_target;
    logic [ByteW-1:0] operand;
    logic [CmdW-1:0]  command;
  } ecpu_in_t;

  typedef struct packed {
    logic [ByteW-1:0] flags_value;
    logic [ByteW-1:0] y_value;
    logic [ByteW-1:0] x_value;
    logic [ByteW-1:0] acc_value;
    logic             branch_taken;
    logic [AddrW-1:0] new_pc;
    logic             write_enable;
    logic [ByteW-1:0] write_data;
  } ecpu_out_t;

  // update N and Z from an 8-bit result
  function automatic logic [ByteW-1:0] set_nz(input logic [ByteW-1:0] p,
                                              input logic [ByteW-1:0] v);
    logic [ByteW-1:0] q;
    q = p;
    q[FLAG_N] = v[ByteW-1];
    q[FLAG_Z] = (v == '0);
    return q;
  endfunction

endpackage

[hdl/eight_bit_cpu_execute_unit.sv]
// execute stage of an 8-bit processor: alu, flags, branch resolution, register file
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  in_     | in  | in_tvalid / in_tready  | in_tdata: command, operand, jump_target,
//          |     |                        |           next_pc
//  out_    | out | out_tvalid / out_tready| out_tdata: write_data, write_enable, new_pc,
//          |     |                        |  branch_taken, acc, x, y, flags
//
// one item per cycle when out_tready is high; path: input register, then result register
// each item executes against the register file in the cycle it leaves the input
// register, so back-to-back items see each other's updates with no bubble
// reset (synchronous, rst_n low) clears a, x, y, sets sp to 0xfd and the status to 0x24
// a stalled result holds in the output register; one more item waits in the input
// register, after which in_tready drops until the output is taken
module eight_bit_cpu_execute_unit
  import ecpu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [5:0] command, [13:6] operand, [29:14] jump_target, [45:30] next_pc, [47:46] unused
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [7:0] write_data, [8] write_enable, [24:9] new_pc, [25] branch_taken,
  // [33:26] acc_value, [41:34] x_value, [49:42] y_value, [57:50] flags_value, [63:58] zero
  output logic [OutDataW-1:0] out_tdata
);

  localparam int unsigned PadW = OutDataW - $bits(ecpu_out_t);

  // input register
  logic     s1_valid_r, s1_valid_nxt;
  ecpu_in_t s1_r;
  logic     s1_adv;

  // result register
  logic      out_valid_r, out_valid_nxt;
  ecpu_out_t out_r, out_nxt;

  // architectural state
  logic [ByteW-1:0] a_r, a_nxt;
  logic [ByteW-1:0] x_r, x_nxt;
  logic [ByteW-1:0] y_r, y_nxt;
  logic [ByteW-1:0] sp_r, sp_nxt;
  logic [ByteW-1:0] p_r, p_nxt;

  // datapath temporaries
  logic [ByteW-1:0] m;
  logic [ByteW-1:0] addend;
  logic [ByteW:0]   sum;
  logic [ByteW-1:0] cmp_reg;
  logic [ByteW:0]   diff;
  logic [ByteW-1:0] rmw;
  logic [AddrW-1:0] br_pc;
  logic             br_cond;
  logic             is_branch;

  // the input register drains whenever the result register is free or being emptied
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready    = !s1_valid_r || s1_adv;
  assign s1_valid_nxt = (in_tvalid && in_tready) || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_tready);

  assign m      = s1_r.operand;
  // sbc is adc of the inverted operand
  assign addend = (s1_r.command == CMD_SBC) ? ~m : m;
  assign sum    = {1'b0, a_r} + {1'b0, addend} + {{ByteW{1'b0}}, p_r[FLAG_C]};
  assign diff   = {1'b0, cmp_reg} - {1'b0, m};
  assign br_pc  = s1_r.next_pc + {{(AddrW-ByteW){m[ByteW-1]}}, m};

  always_comb begin
    unique case (s1_r.command)
      CMD_CPX: cmp_reg = x_r;
      CMD_CPY: cmp_reg = y_r;
      default: cmp_reg = a_r;
    endcase
  end

  // branch condition select
  always_comb begin
    is_branch = 1'b1;
    unique case (s1_r.command)
      CMD_BCC: br_cond = !p_r[FLAG_C];
      CMD_BCS: br_cond =  p_r[FLAG_C];
      CMD_BEQ: br_cond =  p_r[FLAG_Z];
      CMD_BNE: br_cond = !p_r[FLAG_Z];
      CMD_BMI: br_cond =  p_r[FLAG_N];
      CMD_BPL: br_cond = !p_r[FLAG_N];
      CMD_BVC: br_cond = !p_r[FLAG_V];
      CMD_BVS: br_cond =  p_r[FLAG_V];
      default: begin
        br_cond   = 1'b0;
        is_branch = 1'b0;
      end
    endcase
  end

  // main execute decode
  always_comb begin
    a_nxt  = a_r;
    x_nxt  = x_r;
    y_nxt  = y_r;
    sp_nxt = sp_r;
    p_nxt  = p_r;
    rmw    = '0;
    out_nxt = '0;
    out_nxt.new_pc = s1_r.next_pc;
    unique case (s1_r.command)
      CMD_LDA: begin
        a_nxt = m;
        p_nxt = set_nz(p_r, m);
      end
      CMD_LDX: begin
        x_nxt = m;
        p_nxt = set_nz(p_r, m);
      end
      CMD_LDY: begin
        y_nxt = m;
        p_nxt = set_nz(p_r, m);
      end
      CMD_STA: begin
        out_nxt.write_data   = a_r;
        out_nxt.write_enable = 1'b1;
      end
      CMD_STX: begin
        out_nxt.write_data   = x_r;
        out_nxt.write_enable = 1'b1;
      end
      CMD_STY: begin
        out_nxt.write_data   = y_r;
        out_nxt.write_enable = 1'b1;
      end
      CMD_ADC, CMD_SBC: begin
        a_nxt = sum[ByteW-1:0];
        p_nxt = set_nz(p_r, sum[ByteW-1:0]);
        p_nxt[FLAG_C] = sum[ByteW];
        p_nxt[FLAG_V] = (a_r[ByteW-1] ^ sum[ByteW-1]) & (addend[ByteW-1] ^ sum[ByteW-1]);
      end
      CMD_AND: begin
        a_nxt = a_r & m;
        p_nxt = set_nz(p_r, a_r & m);
      end
      CMD_ORA: begin
        a_nxt = a_r | m;
        p_nxt = set_nz(p_r, a_r | m);
      end
      CMD_EOR: begin
        a_nxt = a_r ^ m;
        p_nxt = set_nz(p_r, a_r ^ m);
      end
      CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR, CMD_INC, CMD_DEC: begin
        unique case (s1_r.command)
          CMD_ASL: rmw = {m[ByteW-2:0], 1'b0};
          CMD_LSR: rmw = {1'b0, m[ByteW-1:1]};
          CMD_ROL: rmw = {m[ByteW-2:0], p_r[FLAG_C]};
          CMD_ROR: rmw = {p_r[FLAG_C], m[ByteW-1:1]};
          CMD_INC: rmw = m + 8'd1;
          default: rmw = m - 8'd1;
        endcase
        p_nxt = set_nz(p_r, rmw);
        if (s1_r.command == CMD_ASL || s1_r.command == CMD_ROL) begin
          p_nxt[FLAG_C] = m[ByteW-1];
        end else if (s1_r.command == CMD_LSR || s1_r.command == CMD_ROR) begin
          p_nxt[FLAG_C] = m[0];
        end
        out_nxt.write_data   = rmw;
        out_nxt.write_enable = 1'b1;
      end
      CMD_INX: begin
        x_nxt = x_r + 8'd1;
        p_nxt = set_nz(p_r, x_r + 8'd1);
      end
      CMD_INY: begin
        y_nxt = y_r + 8'd1;
        p_nxt = set_nz(p_r, y_r + 8'd1);
      end
      CMD_DEX: begin
        x_nxt = x_r - 8'd1;
        p_nxt = set_nz(p_r, x_r - 8'd1);
      end
      CMD_DEY: begin
        y_nxt = y_r - 8'd1;
        p_nxt = set_nz(p_r, y_r - 8'd1);
      end
      CMD_CMP, CMD_CPX, CMD_CPY: begin
        // carry means no borrow
        p_nxt = set_nz(p_r, diff[ByteW-1:0]);
        p_nxt[FLAG_C] = !diff[ByteW];
      end
      CMD_BIT: begin
        p_nxt[FLAG_N] = m[FLAG_N];
        p_nxt[FLAG_V] = m[FLAG_V];
        p_nxt[FLAG_Z] = ((a_r & m) == '0);
      end
      CMD_JMP: begin
        out_nxt.new_pc       = s1_r.jump_target;
        out_nxt.branch_taken = 1'b1;
      end
      CMD_CLC: p_nxt[FLAG_C] = 1'b0;
      CMD_CLD: p_nxt[FLAG_D] = 1'b0;
      CMD_CLI: p_nxt[FLAG_I] = 1'b0;
      CMD_CLV: p_nxt[FLAG_V] = 1'b0;
      CMD_SEC: p_nxt[FLAG_C] = 1'b1;
      CMD_SED: p_nxt[FLAG_D] = 1'b1;
      CMD_SEI: p_nxt[FLAG_I] = 1'b1;
      CMD_TAX: begin
        x_nxt = a_r;
        p_nxt = set_nz(p_r, a_r);
      end
      CMD_TAY: begin
        y_nxt = a_r;
        p_nxt = set_nz(p_r, a_r);
      end
      CMD_TSX: begin
        x_nxt = sp_r;
        p_nxt = set_nz(p_r, sp_r);
      end
      CMD_TXA: begin
        a_nxt = x_r;
        p_nxt = set_nz(p_r, x_r);
      end
      CMD_TXS: sp_nxt = x_r;
      CMD_TYA: begin
        a_nxt = y_r;
        p_nxt = set_nz(p_r, y_r);
      end
      // branches are resolved below; nop and unused codes change nothing
      default: ;
    endcase
    if (is_branch && br_cond) begin
      out_nxt.new_pc       = br_pc;
      out_nxt.branch_taken = 1'b1;
    end
    out_nxt.acc_value   = a_nxt;
    out_nxt.x_value     = x_nxt;
    out_nxt.y_value     = y_nxt;
    out_nxt.flags_value = p_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      a_r  <= '0;
      x_r  <= '0;
      y_r  <= '0;
      sp_r <= SP_RESET;
      p_r  <= P_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        a_r  <= a_nxt;
        x_r  <= x_nxt;
        y_r  <= y_nxt;
        sp_r <= sp_nxt;
        p_r  <= p_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_r <= ecpu_in_t'(in_tdata[$bits(ecpu_in_t)-1:0]);
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PadW{1'b0}}, out_r};

  // the always-one status bit never drops
  a_flag_one: assert property (@(posedge clk) disable iff (!rst_n) p_r[FLAG_ONE])
    else $error("status bit 5 cleared");

  // a waiting item stays in the input register until it executes
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("input item dropped");

  // every executed item produces a result
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("executed item gave no result");

  // state only moves when an item executes
  a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(a_r) && $stable(x_r) && $stable(y_r) && $stable(sp_r) && $stable(p_r))
    else $error("state changed without an item");

endmodule
